/* src/wheel_odometry_integrator_defines.svh */
// assertion macros for the wheel odometry integrator
`ifndef WHEEL_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define WHEEL_ODOMETRY_INTEGRATOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define WODO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define WODO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wodo_pkg.sv */
// shared types and constants of the wheel odometry integrator
package wodo_pkg;

    localparam int POS_W      = 32;
    localparam int TIME_W     = 32;
    localparam int JUMP_W     = 31;
    localparam int TPS_W      = 32;
    localparam int VEL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = POS_W + TPS_W;
    localparam int KIN_SUM_W  = POS_W + 3;

    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = POS_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = $clog2(NUM_AXES);

    localparam logic [AXIS_W-1:0] AXIS_X   = AXIS_W'(0);
    localparam logic [AXIS_W-1:0] AXIS_Y   = AXIS_W'(1);
    localparam logic [AXIS_W-1:0] AXIS_YAW = AXIS_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = CFG_IDX_W'(1);

    localparam logic [JUMP_W-1:0] JUMP_LIMIT_RST = JUMP_W'(655);
    localparam logic [TPS_W-1:0]  TPS_RST        = TPS_W'(1000000);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_KIN,
        SEQ_VEL_GO,
        SEQ_VEL_WAIT,
        SEQ_HOLD
    } seq_state_t;

    typedef enum logic [2:0] {
        VU_IDLE,
        VU_MUL,
        VU_CHECK,
        VU_DIV,
        VU_DONE
    } vu_state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dy;
        logic signed [POS_W-1:0] dt;
        logic [TIME_W-1:0]       elapsed;
        logic                    rot;
        logic                    jump;
        logic                    terr;
    } kin_t;

    typedef struct packed {
        logic                    done;
        logic signed [VEL_W-1:0] vel;
    } vu_resp_t;

endpackage

/* src/wodo_kin.sv */
// wheel deltas, planar step, rotation and jump detection
module wodo_kin (
    input  logic signed [wodo_pkg::POS_W-1:0]  wheel1_cur,
    input  logic signed [wodo_pkg::POS_W-1:0]  wheel2_cur,
    input  logic signed [wodo_pkg::POS_W-1:0]  wheel4_cur,
    input  logic signed [wodo_pkg::POS_W-1:0]  wheel1_last,
    input  logic signed [wodo_pkg::POS_W-1:0]  wheel2_last,
    input  logic signed [wodo_pkg::POS_W-1:0]  wheel4_last,
    input  logic [wodo_pkg::TIME_W-1:0]        time_cur,
    input  logic [wodo_pkg::TIME_W-1:0]        time_last,
    input  logic [wodo_pkg::JUMP_W-1:0]        jump_limit,
    output wodo_pkg::kin_t                     kin
);
    import wodo_pkg::*;

    logic signed [POS_W-1:0]     d1;
    logic signed [POS_W-1:0]     d2;
    logic signed [POS_W-1:0]     d4;
    logic signed [KIN_SUM_W-1:0] d1_e;
    logic signed [KIN_SUM_W-1:0] d2_e;
    logic signed [KIN_SUM_W-1:0] d3_e;
    logic signed [KIN_SUM_W-1:0] d4_e;
    logic signed [KIN_SUM_W-1:0] sum_x;
    logic signed [KIN_SUM_W-1:0] sum_y;
    logic signed [KIN_SUM_W-1:0] diff_t;
    logic signed [KIN_SUM_W-1:0] shr_x;
    logic signed [KIN_SUM_W-1:0] shr_y;
    logic signed [KIN_SUM_W-1:0] shr_t;
    logic signed [POS_W:0]       dx_e;
    logic signed [POS_W:0]       dy_e;
    logic signed [POS_W:0]       lim_e;
    logic                        rot;

    always_comb
    begin
        d1   = wheel1_cur - wheel1_last;
        d2   = wheel2_cur - wheel2_last;
        d4   = wheel4_cur - wheel4_last;
        rot  = (d2 != '0) && (d4 != '0) && (d2[POS_W-1] ^ d4[POS_W-1]);
        d1_e = KIN_SUM_W'(d1);
        d2_e = KIN_SUM_W'(d2);
        d4_e = KIN_SUM_W'(d4);
        d3_e = rot ? -d1_e : d1_e;

        sum_x  = d1_e + d2_e + d3_e + d4_e;
        sum_y  = d1_e - d2_e + d3_e - d4_e;
        diff_t = d4_e - d2_e;
        shr_x  = sum_x >>> 2;
        shr_y  = sum_y >>> 2;
        shr_t  = diff_t >>> 1;

        kin.dx      = shr_x[POS_W-1:0];
        kin.dy      = shr_y[POS_W-1:0];
        kin.dt      = shr_t[POS_W-1:0];
        kin.rot     = rot;
        kin.elapsed = time_cur - time_last;
        kin.terr    = (kin.elapsed == '0);

        dx_e     = (POS_W+1)'(kin.dx);
        dy_e     = (POS_W+1)'(kin.dy);
        lim_e    = $signed({{(POS_W+1-JUMP_W){1'b0}}, jump_limit});
        kin.jump = (dx_e > lim_e) || (dy_e > lim_e);
    end

endmodule

/* src/wodo_vel_unit.sv */
// shared multiply and radix-4 restoring divide unit for velocities
module wodo_vel_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [wodo_pkg::POS_W-1:0] step,
    input  logic [wodo_pkg::TIME_W-1:0]       elapsed,
    input  logic [wodo_pkg::TPS_W-1:0]        tps,
    output wodo_pkg::vu_resp_t                resp
);
    import wodo_pkg::*;

    vu_state_t               state_reg;
    vu_state_t               state_next;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic                    neg_reg;
    logic                    sat_reg;
    logic [POS_W-1:0]        mag_reg;
    logic [TIME_W-1:0]       den_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [TIME_W-1:0]       rem_reg;
    logic [POS_W-1:0]        quo_reg;

    logic                    ld_op;
    logic                    ld_prod;
    logic                    ld_div;
    logic                    ld_sat;
    logic                    div_step;
    logic                    hi_over;
    logic [PROD_W-1:0]       prod_mul;
    logic [TIME_W-1:0]       rem_v;
    logic [POS_W-1:0]        quo_v;
    logic [TIME_W:0]         trial;
    logic                    qbit;
    logic [VEL_W-1:0]        lim;
    logic [VEL_W-1:0]        q_abs;
    logic [VEL_W-1:0]        q_sat;

    assign prod_mul = PROD_W'(mag_reg) * PROD_W'(tps);
    assign hi_over  = (prod_reg[PROD_W-1 -: TIME_W] >= den_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            VU_IDLE:  if (start) state_next = VU_MUL;
            VU_MUL:   state_next = VU_CHECK;
            VU_CHECK: state_next = hi_over ? VU_DONE : VU_DIV;
            VU_DIV:   if (cnt_reg == DIV_CNT_W'(DIV_CYCLES-1)) state_next = VU_DONE;
            VU_DONE:  state_next = VU_IDLE;
            default:  state_next = VU_IDLE;
        endcase
    end

    always_comb
    begin
        ld_op    = (state_reg == VU_IDLE) && start;
        ld_prod  = (state_reg == VU_MUL);
        ld_sat   = (state_reg == VU_CHECK) && hi_over;
        ld_div   = (state_reg == VU_CHECK) && !hi_over;
        div_step = (state_reg == VU_DIV);
    end

    // two quotient bits per cycle
    always_comb
    begin
        rem_v = rem_reg;
        quo_v = quo_reg;
        trial = '0;
        qbit  = 1'b0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {rem_v, quo_v[POS_W-1]};
            qbit  = (trial >= {1'b0, den_reg});
            if (qbit)
            begin
                trial = trial - {1'b0, den_reg};
            end
            rem_v = trial[TIME_W-1:0];
            quo_v = {quo_v[POS_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= VU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ld_div)
            begin
                cnt_reg <= '0;
            end
            else if (div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_op)
        begin
            neg_reg <= step[POS_W-1];
            mag_reg <= step[POS_W-1] ? POS_W'(-step) : POS_W'(step);
            den_reg <= elapsed;
            sat_reg <= 1'b0;
        end
        if (ld_prod)
        begin
            prod_reg <= prod_mul;
        end
        if (ld_sat)
        begin
            sat_reg <= 1'b1;
        end
        if (ld_div)
        begin
            rem_reg <= prod_reg[PROD_W-1 -: TIME_W];
            quo_reg <= prod_reg[POS_W-1:0];
        end
        else if (div_step)
        begin
            rem_reg <= rem_v;
            quo_reg <= quo_v;
        end
    end

    always_comb
    begin
        lim   = {1'b0, {(VEL_W-1){1'b1}}} + VEL_W'(neg_reg);
        q_abs = sat_reg ? '1 : VEL_W'(quo_reg);
        q_sat = (q_abs > lim) ? lim : q_abs;
        resp.done = (state_reg == VU_DONE);
        resp.vel  = neg_reg ? $signed(-q_sat) : $signed(q_sat);
    end

endmodule

/* src/wheel_odometry_integrator.sv */
// mecanum wheel odometry integrator, top level
//
// input channel: in_valid/in_ready with wheel1_pos, wheel2_pos, wheel4_pos and
// sample_time. in_ready is high only while no item is in flight.
// output channel: out_valid/out_ready with the pose, the three velocities and
// the rotating, jump_seen and time_error flags; one result per input.
// config channel: cfg_valid/cfg_ready, always ready; cfg_index 0 writes
// jump_limit, index 1 ticks_per_second, other indexes are dropped.
// the three velocities go one after another through a single multiplier and
// a 2-bit-per-cycle divider; a velocity that saturates early skips the
// division, and when elapsed time is zero all three are skipped. the next
// input can be taken in the cycle after the result is loaded.
// a finished result sits in the output register; the next input is taken
// while it waits, and a later result holds until out_ready frees the register.
// reset clears the pose, the last positions and timestamp, and loads the
// register defaults (jump_limit 655, ticks_per_second 1000000).
module wheel_odometry_integrator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wodo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wodo_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [wodo_pkg::POS_W-1:0]    wheel1_pos,
    input  logic signed [wodo_pkg::POS_W-1:0]    wheel2_pos,
    input  logic signed [wodo_pkg::POS_W-1:0]    wheel4_pos,
    input  logic [wodo_pkg::TIME_W-1:0]          sample_time,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [wodo_pkg::POS_W-1:0]    pose_x,
    output logic signed [wodo_pkg::POS_W-1:0]    pose_y,
    output logic signed [wodo_pkg::POS_W-1:0]    pose_yaw,
    output logic signed [wodo_pkg::VEL_W-1:0]    vel_x,
    output logic signed [wodo_pkg::VEL_W-1:0]    vel_y,
    output logic signed [wodo_pkg::VEL_W-1:0]    vel_yaw,
    output logic                                 rotating,
    output logic                                 jump_seen,
    output logic                                 time_error
);
    import wodo_pkg::*;

    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic [JUMP_W-1:0]       jump_limit_reg;
    logic [TPS_W-1:0]        tps_reg;

    logic signed [POS_W-1:0] w1_reg;
    logic signed [POS_W-1:0] w2_reg;
    logic signed [POS_W-1:0] w4_reg;
    logic [TIME_W-1:0]       now_reg;
    logic signed [POS_W-1:0] last_w1_reg;
    logic signed [POS_W-1:0] last_w2_reg;
    logic signed [POS_W-1:0] last_w4_reg;
    logic [TIME_W-1:0]       last_time_reg;
    logic signed [POS_W-1:0] acc_x_reg;
    logic signed [POS_W-1:0] acc_y_reg;
    logic signed [POS_W-1:0] acc_yaw_reg;

    kin_t                    kin;
    kin_t                    kin_reg;
    logic [AXIS_W-1:0]       axis_reg;
    logic signed [VEL_W-1:0] vel_reg [NUM_AXES];
    logic signed [POS_W-1:0] vu_step;
    vu_resp_t                vu_resp;

    logic                    out_valid_reg;
    logic signed [POS_W-1:0] pose_x_reg;
    logic signed [POS_W-1:0] pose_y_reg;
    logic signed [POS_W-1:0] pose_yaw_reg;
    logic signed [VEL_W-1:0] vel_x_reg;
    logic signed [VEL_W-1:0] vel_y_reg;
    logic signed [VEL_W-1:0] vel_yaw_reg;
    logic                    rot_reg;
    logic                    jump_reg;
    logic                    terr_reg;

    logic                    in_xfer;
    logic                    kin_load;
    logic                    vu_start;
    logic                    out_load;
    logic                    last_axis;

    wodo_kin u_kin (
        .wheel1_cur  (w1_reg),
        .wheel2_cur  (w2_reg),
        .wheel4_cur  (w4_reg),
        .wheel1_last (last_w1_reg),
        .wheel2_last (last_w2_reg),
        .wheel4_last (last_w4_reg),
        .time_cur    (now_reg),
        .time_last   (last_time_reg),
        .jump_limit  (jump_limit_reg),
        .kin         (kin)
    );

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:   vu_step = kin_reg.dx;
            AXIS_Y:   vu_step = kin_reg.dy;
            AXIS_YAW: vu_step = kin_reg.dt;
            default:  vu_step = kin_reg.dt;
        endcase
    end

    wodo_vel_unit u_vel_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (vu_start),
        .step    (vu_step),
        .elapsed (kin_reg.elapsed),
        .tps     (tps_reg),
        .resp    (vu_resp)
    );

    assign last_axis = (axis_reg == AXIS_YAW);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:     if (in_valid) state_next = SEQ_KIN;
            SEQ_KIN:      state_next = kin.terr ? SEQ_HOLD : SEQ_VEL_GO;
            SEQ_VEL_GO:   state_next = SEQ_VEL_WAIT;
            SEQ_VEL_WAIT: if (vu_resp.done) state_next = last_axis ? SEQ_HOLD : SEQ_VEL_GO;
            SEQ_HOLD:     if (!out_valid_reg || out_ready) state_next = SEQ_IDLE;
            default:      state_next = SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == SEQ_IDLE);
        kin_load = (state_reg == SEQ_KIN);
        vu_start = (state_reg == SEQ_VEL_GO);
        out_load = (state_reg == SEQ_HOLD) && (!out_valid_reg || out_ready);
    end

    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            jump_limit_reg <= JUMP_LIMIT_RST;
            tps_reg        <= TPS_RST;
            last_w1_reg    <= '0;
            last_w2_reg    <= '0;
            last_w4_reg    <= '0;
            last_time_reg  <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_yaw_reg    <= '0;
            axis_reg       <= AXIS_X;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_JUMP_LIMIT)
                begin
                    jump_limit_reg <= cfg_data[JUMP_W-1:0];
                end
                else if (cfg_index == CFG_TICKS_PER_SEC)
                begin
                    tps_reg <= cfg_data[TPS_W-1:0];
                end
            end
            if (kin_load)
            begin
                last_w1_reg   <= w1_reg;
                last_w2_reg   <= w2_reg;
                last_w4_reg   <= w4_reg;
                last_time_reg <= now_reg;
                acc_x_reg     <= acc_x_reg + kin.dx;
                acc_y_reg     <= acc_y_reg + kin.dy;
                acc_yaw_reg   <= acc_yaw_reg + kin.dt;
                axis_reg      <= AXIS_X;
            end
            else if ((state_reg == SEQ_VEL_WAIT) && vu_resp.done && !last_axis)
            begin
                axis_reg <= axis_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            w1_reg  <= wheel1_pos;
            w2_reg  <= wheel2_pos;
            w4_reg  <= wheel4_pos;
            now_reg <= sample_time;
        end
        if (kin_load)
        begin
            kin_reg <= kin;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                vel_reg[i] <= '0;
            end
        end
        else if ((state_reg == SEQ_VEL_WAIT) && vu_resp.done)
        begin
            vel_reg[axis_reg] <= vu_resp.vel;
        end
        if (out_load)
        begin
            pose_x_reg   <= acc_x_reg;
            pose_y_reg   <= acc_y_reg;
            pose_yaw_reg <= acc_yaw_reg;
            vel_x_reg    <= vel_reg[AXIS_X];
            vel_y_reg    <= vel_reg[AXIS_Y];
            vel_yaw_reg  <= vel_reg[AXIS_YAW];
            rot_reg      <= kin_reg.rot;
            jump_reg     <= kin_reg.jump;
            terr_reg     <= kin_reg.terr;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pose_x     = pose_x_reg;
    assign pose_y     = pose_y_reg;
    assign pose_yaw   = pose_yaw_reg;
    assign vel_x      = vel_x_reg;
    assign vel_y      = vel_y_reg;
    assign vel_yaw    = vel_yaw_reg;
    assign rotating   = rot_reg;
    assign jump_seen  = jump_reg;
    assign time_error = terr_reg;

endmodule

/* src/wodo_checker.sv */
// port-level assertions for the wheel odometry integrator and their bind
`include "wheel_odometry_integrator_defines.svh"

module wodo_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [wodo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [wodo_pkg::CFG_DATA_W-1:0]      cfg_data,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic signed [wodo_pkg::POS_W-1:0]    wheel1_pos,
    input logic signed [wodo_pkg::POS_W-1:0]    wheel2_pos,
    input logic signed [wodo_pkg::POS_W-1:0]    wheel4_pos,
    input logic [wodo_pkg::TIME_W-1:0]          sample_time,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [wodo_pkg::POS_W-1:0]    pose_x,
    input logic signed [wodo_pkg::POS_W-1:0]    pose_y,
    input logic signed [wodo_pkg::POS_W-1:0]    pose_yaw,
    input logic signed [wodo_pkg::VEL_W-1:0]    vel_x,
    input logic signed [wodo_pkg::VEL_W-1:0]    vel_y,
    input logic signed [wodo_pkg::VEL_W-1:0]    vel_yaw,
    input logic                                 rotating,
    input logic                                 jump_seen,
    input logic                                 time_error
);

    // a stalled result stays offered
    `WODO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")

    // a stalled result keeps its payload
    `WODO_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(pose_x) && $stable(pose_y) && $stable(pose_yaw) && $stable(vel_x) && $stable(vel_y) && $stable(vel_yaw), "payload changed while stalled")

    // zero elapsed time forces zero velocities
    `WODO_ASSERT_NOW(a_terr_zero_vel, clk, rst_n, out_valid && time_error, (vel_x == '0) && (vel_y == '0) && (vel_yaw == '0), "velocity nonzero with time_error")

    // one item in flight at a time
    `WODO_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind wheel_odometry_integrator wodo_checker u_wodo_checker (.*);
